### rtl/ide_pkg.sv
// ----------------------------------------------------------------------------
// ide_pkg
// shared widths, opcodes and status codes of the indexed deque engine
// ----------------------------------------------------------------------------
package ide_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int WORD_W    = 32;
   localparam int POS_W     = 6;
   localparam int CNT_W     = 7;
   localparam int OP_W      = 4;
   localparam int ST_W      = 3;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_HEAD  = 4'd0,
      OP_PUSH_TAIL  = 4'd1,
      OP_POP_HEAD   = 4'd2,
      OP_POP_TAIL   = 4'd3,
      OP_REMOVE_AT  = 4'd4,
      OP_PEEK_FRONT = 4'd5,
      OP_PEEK_BACK  = 4'd6,
      OP_READ_AT    = 4'd7,
      OP_SEARCH     = 4'd8,
      OP_MOVE_FRONT = 4'd9,
      OP_UPDATE_AT  = 4'd10,
      OP_FIND_MIN   = 4'd11
   } opcode_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_RANGE     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_DONE = 3'b100
   } state_type;

endpackage

### rtl/ide_ram.sv
// ----------------------------------------------------------------------------
// ide_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ide_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/indexed_deque_engine.sv
// ----------------------------------------------------------------------------
// indexed_deque_engine
// bounded double-ended queue of signed words in a circular ram
// ----------------------------------------------------------------------------
// usage
//   req channel carries one operation word: opcode, value, position
//   rsp channel returns exactly one word per operation: result word,
//   result position, status, item count and empty flag
//   push, update-at, error cases and unused opcodes answer in the cycle of
//   acceptance, so the response is visible in the next cycle
//   pop, peek and read-at do one ram read, then capture the word, then
//   close the walk, then post the response
//   remove-at, move-to-front, search and find-min walk the ram one entry per
//   cycle, a rate set by the single ram read port
//   one operation is in flight at a time; req_ready is low while walking
//   the response register holds while rsp_ready is low, and a new request
//   is taken only once that register is free or being emptied
//   reset empties the deque at once; ram contents are not cleared
// ----------------------------------------------------------------------------
module indexed_deque_engine
   import ide_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [WORD_W-1:0] req_value,
   input  logic [POS_W-1:0]  req_position,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_result_word,
   output logic [POS_W-1:0]  rsp_result_position,
   output logic [ST_W-1:0]   rsp_status,
   output logic [CNT_W-1:0]  rsp_item_count,
   output logic              rsp_is_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int IW = $clog2(DEPTH + 1);

   // physical slot of logical index i counted from the front
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f,
                                             input logic [IW-1:0] i);
      logic [IW:0] s;
      s = (IW+1)'(f) + (IW+1)'(i);
      if (s >= (IW+1)'(DEPTH)) begin
         s = s - (IW+1)'(DEPTH);
      end
      return AW'(s);
   endfunction

   // control state
   state_type         state_ff, state_in;
   logic [AW-1:0]     front_ff, front_in;
   logic [IW-1:0]     occ_ff, occ_in;
   logic [IW-1:0]     remain_ff, remain_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic [IW-1:0]     pidx_ff, pidx_in;
   logic              pv_ff, pv_in;
   logic              dir_up_ff, dir_up_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // latched operation and walk data
   logic [OP_W-1:0]   op_ff, op_in;
   logic [WORD_W-1:0] val_ff, val_in;
   logic [IW-1:0]     pos_ff, pos_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic [POS_W-1:0]  rpos_ff, rpos_in;

   // response register
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [ST_W-1:0]   rsp_st_ff, rsp_st_in;
   logic [IW-1:0]     rsp_cnt_ff, rsp_cnt_in;

   // ram port
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   logic              out_free, accept, positional, full;

   ide_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && out_free;
   assign accept     = req_valid && req_ready;
   assign full       = (occ_ff == IW'(DEPTH));
   assign positional = (req_opcode == OP_REMOVE_AT) || (req_opcode == OP_READ_AT) ||
                       (req_opcode == OP_MOVE_FRONT) || (req_opcode == OP_UPDATE_AT);

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      occ_in       = occ_ff;
      remain_in    = remain_ff;
      rd_idx_in    = rd_idx_ff;
      pidx_in      = pidx_ff;
      pv_in        = 1'b0;
      dir_up_in    = dir_up_ff;
      found_in     = found_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      data_in      = data_ff;
      rpos_in      = rpos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = val_ff;
      rd_en        = 1'b0;
      rd_addr      = slot_of(front_ff, rd_idx_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_opcode;
               val_in      = req_value;
               pos_in      = IW'(req_position);
               found_in    = 1'b0;
               rpos_in     = '0;
               dir_up_in   = 1'b1;
               rsp_word_in = '0;
               rsp_pos_in  = '0;
               rsp_st_in   = ST_OK;
               // immediate answer unless a walk is started below
               rsp_valid_in = 1'b1;
               if (req_opcode == OP_PUSH_HEAD || req_opcode == OP_PUSH_TAIL) begin
                  if (full) begin
                     rsp_st_in = ST_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = req_value;
                     if (req_opcode == OP_PUSH_HEAD) begin
                        front_in = slot_of(front_ff, IW'(DEPTH - 1));
                        wr_addr  = slot_of(front_ff, IW'(DEPTH - 1));
                     end else begin
                        wr_addr = slot_of(front_ff, occ_ff);
                     end
                     occ_in = occ_ff + 1'b1;
                  end
               end else if (req_opcode > OP_FIND_MIN) begin
                  rsp_st_in = ST_OK;
               end else if (occ_ff == '0) begin
                  rsp_st_in = ST_EMPTY;
               end else if (positional && (int'(req_position) >= int'(occ_ff))) begin
                  rsp_st_in = ST_RANGE;
               end else if (req_opcode == OP_UPDATE_AT) begin
                  wr_en   = 1'b1;
                  wr_addr = slot_of(front_ff, IW'(req_position));
                  wr_data = req_value;
               end else begin
                  rsp_valid_in = rsp_valid_ff && !rsp_ready;
                  state_in     = S_WALK;
                  remain_in    = IW'(1);
                  rd_idx_in    = '0;
                  priority case (req_opcode)
                     OP_POP_TAIL, OP_PEEK_BACK: rd_idx_in = occ_ff - 1'b1;
                     OP_READ_AT: rd_idx_in = IW'(req_position);
                     OP_REMOVE_AT: begin
                        rd_idx_in = IW'(req_position);
                        remain_in = occ_ff - IW'(req_position);
                     end
                     OP_MOVE_FRONT: begin
                        rd_idx_in = IW'(req_position);
                        remain_in = IW'(req_position) + 1'b1;
                        dir_up_in = 1'b0;
                     end
                     OP_SEARCH, OP_FIND_MIN: remain_in = occ_ff;
                     default: rd_idx_in = '0;
                  endcase
               end
               rsp_cnt_in = occ_in;
            end
         end

         S_WALK: begin
            // issue one read per cycle
            if (remain_ff != '0) begin
               rd_en     = 1'b1;
               pv_in     = 1'b1;
               pidx_in   = rd_idx_ff;
               remain_in = remain_ff - 1'b1;
               rd_idx_in = dir_up_ff ? rd_idx_ff + 1'b1 : rd_idx_ff - 1'b1;
            end
            // consume the word read last cycle
            if (pv_ff) begin
               priority case (op_ff)
                  OP_REMOVE_AT: begin
                     if (pidx_ff == pos_ff) begin
                        data_in = rd_data;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot_of(front_ff, pidx_ff - 1'b1);
                        wr_data = rd_data;
                     end
                  end
                  OP_MOVE_FRONT: begin
                     if (pidx_ff == pos_ff) begin
                        data_in = rd_data;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot_of(front_ff, pidx_ff + 1'b1);
                        wr_data = rd_data;
                     end
                  end
                  OP_SEARCH: begin
                     if (!found_ff && rd_data == val_ff) begin
                        found_in = 1'b1;
                        rpos_in  = POS_W'(pidx_ff);
                     end
                  end
                  OP_FIND_MIN: begin
                     if (pidx_ff == '0 || $signed(rd_data) <= $signed(data_ff)) begin
                        data_in = rd_data;
                        rpos_in = POS_W'(pidx_ff);
                     end
                  end
                  default: data_in = rd_data;
               endcase
            end
            if (remain_ff == '0 && !pv_ff) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // moved word lands at the front
            if (op_ff == OP_MOVE_FRONT) begin
               wr_en   = 1'b1;
               wr_addr = front_ff;
               wr_data = data_ff;
            end
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_st_in    = ST_OK;
               rsp_word_in  = '0;
               rsp_pos_in   = '0;
               priority case (op_ff)
                  OP_POP_HEAD: begin
                     rsp_word_in = data_ff;
                     front_in    = slot_of(front_ff, IW'(1));
                     occ_in      = occ_ff - 1'b1;
                  end
                  OP_POP_TAIL, OP_REMOVE_AT: begin
                     rsp_word_in = data_ff;
                     occ_in      = occ_ff - 1'b1;
                  end
                  OP_PEEK_FRONT, OP_PEEK_BACK, OP_READ_AT: rsp_word_in = data_ff;
                  OP_SEARCH: begin
                     rsp_pos_in = rpos_ff;
                     if (!found_ff) begin
                        rsp_st_in = ST_NOT_FOUND;
                     end
                  end
                  OP_FIND_MIN: rsp_pos_in = rpos_ff;
                  default: rsp_word_in = '0;
               endcase
               rsp_cnt_in = occ_in;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         remain_ff    <= '0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         remain_ff    <= remain_in;
         pv_ff        <= pv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      pidx_ff     <= pidx_in;
      dir_up_ff   <= dir_up_in;
      op_ff       <= op_in;
      val_ff      <= val_in;
      pos_ff      <= pos_in;
      data_ff     <= data_in;
      rpos_ff     <= rpos_in;
      rsp_word_ff <= rsp_word_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_word     = rsp_word_ff;
   assign rsp_result_position = rsp_pos_ff;
   assign rsp_status          = rsp_st_ff;
   assign rsp_item_count      = CNT_W'(rsp_cnt_ff);
   assign rsp_is_empty        = (rsp_cnt_ff == '0);

   // occupancy never passes the ram depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= IW'(DEPTH))
      else $error("occupancy above depth");

   // a request is only taken while no walk is running
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == S_IDLE && !pv_ff))
      else $error("request taken during a walk");

   // occupancy only moves when a request is taken or a walk finishes
   a_occ_move: assert property (@(posedge clock) disable iff (reset)
      (!accept && state_ff != S_DONE) |=> $stable(occ_ff))
      else $error("occupancy changed outside an operation");

   // a walk never writes and reads the same ram slot in one cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("ram read and write collide");

endmodule
